>>> hdl/srde_pkg.sv
// ----------------------------------------------------------------------------
// srde_pkg
// Shared constants and types for the signed radix digit emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package srde_pkg;

   // digit table geometry
   localparam int MAX_RADIX  = 32;
   localparam int CHAR_W     = 8;
   localparam int WORD_BYTES = 8;
   localparam int DIGIT_W    = $clog2(MAX_RADIX);
   localparam int RADIX_W    = 6;
   localparam int NUM_W      = 32;
   localparam int COUNT_W    = $clog2(NUM_W);

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] REG_RADIX        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DIGIT_WORD_0 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DIGIT_WORD_1 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_DIGIT_WORD_2 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_DIGIT_WORD_3 = 3'd4;

   // character limits
   localparam logic [CHAR_W-1:0] CHAR_LOW   = 8'd32;
   localparam logic [CHAR_W-1:0] CHAR_HIGH  = 8'd126;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   // digit table, digit k in byte k
   typedef logic [MAX_RADIX-1:0][CHAR_W-1:0] digit_table_type;

   // divider request and response
   typedef struct packed {
      logic               start;
      logic [NUM_W-1:0]   dividend;
      logic [RADIX_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [NUM_W-1:0]   quotient;
      logic [DIGIT_W-1:0] remainder;
   } div_rsp_type;

endpackage

`default_nettype wire

>>> hdl/signed_radix_digit_emitter_unit.sv
// ----------------------------------------------------------------------------
// signed_radix_digit_emitter_unit
// Converts a signed 32-bit number to text in a configured radix.
// ----------------------------------------------------------------------------
// Usage:
//   csr_*  : write radix (index 0) and the four digit words (index 1..4);
//            always ready, write only while no number is in flight.
//   req_*  : one number per word; req_tready is high only while idle.
//   rsp_*  : one character per word, tlast on the final digit.
// Sequence per number with R digits in the table and D digits of output:
//   an accept step, a check of each of the R table digits, a sign step,
//   then one division per digit in the single one-bit-per-cycle divider,
//   then D emit steps, which wait while the output register is stalled.
//   An invalid table drops the number with no output.
// Reset clears the registers to zero (invalid table) and empties the
// output register. When rsp_tready is low the output register holds its
// character and the sequencer waits before writing another; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_radix_digit_emitter_unit
   import srde_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // configuration write
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   // number in
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [NUM_W-1:0]       req_tdata,   // [31:0] number
   // characters out
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [CHAR_W-1:0]           rsp_tdata,   // [7:0] character
   output logic                        rsp_tlast    // last
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_SIGN  = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [RADIX_W-1:0] radix_ff;
   digit_table_type    table_ff;
   logic [NUM_W-1:0]   mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic [DIGIT_W-1:0] chk_ff, chk_in;
   logic [DIGIT_W:0]   nd_ff, nd_in;
   logic [DIGIT_W-1:0] k_ff, k_in;
   logic [DIGIT_W-1:0] rev_ff [MAX_RADIX];
   logic               rev_we;
   logic [DIGIT_W-1:0] rev_rd;
   logic               out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]  out_char_ff, out_char_in;
   logic               out_last_ff, out_last_in;
   logic               slot_free;
   logic               radix_ok;
   logic               digit_bad;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= '0;
         table_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_RADIX:        radix_ff <= csr_data[RADIX_W-1:0];
            REG_DIGIT_WORD_0: table_ff[0*WORD_BYTES +: WORD_BYTES] <= csr_data;
            REG_DIGIT_WORD_1: table_ff[1*WORD_BYTES +: WORD_BYTES] <= csr_data;
            REG_DIGIT_WORD_2: table_ff[2*WORD_BYTES +: WORD_BYTES] <= csr_data;
            REG_DIGIT_WORD_3: table_ff[3*WORD_BYTES +: WORD_BYTES] <= csr_data;
            default: ;
         endcase
      end
   end

   assign radix_ok = (radix_ff >= RADIX_W'(2)) && (radix_ff <= RADIX_W'(MAX_RADIX));

   srde_digit_check u_check (
      .table_in (table_ff),
      .index    (chk_ff),
      .bad      (digit_bad)
   );

   srde_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign slot_free  = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rev_rd     = rev_ff[k_ff];

   // sequencer
   always_comb begin
      state_in         = state_ff;
      mag_in           = mag_ff;
      neg_in           = neg_ff;
      chk_in           = chk_ff;
      nd_in            = nd_ff;
      k_in             = k_ff;
      rev_we           = 1'b0;
      out_valid_in     = out_valid_ff && !rsp_tready;
      out_char_in      = out_char_ff;
      out_last_in      = out_last_ff;
      div_req.start    = 1'b0;
      div_req.dividend = div_rsp.quotient;
      div_req.divisor  = radix_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               neg_in = req_tdata[NUM_W-1];
               mag_in = req_tdata[NUM_W-1] ? (NUM_W'(0) - req_tdata) : req_tdata;
               chk_in = '0;
               nd_in  = '0;
               if (radix_ok) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (digit_bad) begin
               state_in = ST_IDLE;
            end else if ({1'b0, chk_ff} == radix_ff - RADIX_W'(1)) begin
               state_in = ST_SIGN;
            end else begin
               chk_in = chk_ff + 1'b1;
            end
         end
         ST_SIGN: begin
            div_req.dividend = mag_ff;
            if (!neg_ff || slot_free) begin
               if (neg_ff) begin
                  out_valid_in = 1'b1;
                  out_char_in  = CHAR_MINUS;
                  out_last_in  = 1'b0;
               end
               div_req.start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               rev_we = 1'b1;
               nd_in  = nd_ff + 1'b1;
               mag_in = div_rsp.quotient;
               if ((div_rsp.quotient != '0) && (nd_ff < (DIGIT_W+1)'(MAX_RADIX - 1))) begin
                  div_req.start = 1'b1;
               end else begin
                  k_in     = nd_ff[DIGIT_W-1:0];
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_char_in  = table_ff[rev_rd];
               out_last_in  = (k_ff == '0);
               if (k_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in = k_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      chk_ff      <= chk_in;
      nd_ff       <= nd_in;
      k_ff        <= k_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   // remainder store, least significant digit first
   always_ff @(posedge clock) begin
      if (rev_we) begin
         rev_ff[nd_ff[DIGIT_W-1:0]] <= div_rsp.remainder;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

>>> hdl/srde_divider.sv
// ----------------------------------------------------------------------------
// srde_divider
// Restoring divider, one quotient bit per cycle, 32-bit dividend by radix.
// ----------------------------------------------------------------------------
`default_nettype none

module srde_divider
   import srde_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);

   logic [NUM_W-1:0]   quo_ff, quo_in;
   logic [DIGIT_W-1:0] rem_ff, rem_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [RADIX_W-1:0] dvs_ff, dvs_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DIGIT_W:0]   trial;

   // one shift-compare-subtract step
   assign trial = {rem_ff, quo_ff[NUM_W-1]};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      dvs_in  = dvs_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         cnt_in  = '0;
         dvs_in  = req.divisor;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= (DIGIT_W+1)'(dvs_ff)) begin
            rem_in = DIGIT_W'(trial - (DIGIT_W+1)'(dvs_ff));
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIGIT_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == COUNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

`default_nettype wire

>>> hdl/srde_digit_check.sv
// ----------------------------------------------------------------------------
// srde_digit_check
// Checks one table digit: printable, not a sign, no match among earlier ones.
// ----------------------------------------------------------------------------
`default_nettype none

module srde_digit_check
   import srde_pkg::*;
(
   input  wire digit_table_type    table_in,
   input  wire logic [DIGIT_W-1:0] index,
   output logic                    bad
);

   logic [CHAR_W-1:0] c;
   logic              bad_char;
   logic              dup;

   assign c = table_in[index];

   // range and sign characters
   assign bad_char = (c < CHAR_LOW) || (c > CHAR_HIGH) ||
                     (c == CHAR_PLUS) || (c == CHAR_MINUS);

   // compare against every earlier digit at once
   always_comb begin
      dup = 1'b0;
      for (int j = 0; j < MAX_RADIX; j++) begin
         if ((DIGIT_W'(j) < index) && (table_in[j] == c)) begin
            dup = 1'b1;
         end
      end
   end

   assign bad = bad_char || dup;

endmodule

`default_nettype wire

>>> hdl/srde_checker.sv
// ----------------------------------------------------------------------------
// srde_checker
// Port-level checks for the signed radix digit emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module srde_checker
   import srde_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   csr_valid,
   input wire logic                   csr_ready,
   input wire logic [CSR_INDEX_W-1:0] csr_index,
   input wire logic [CSR_DATA_W-1:0]  csr_data,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic [NUM_W-1:0]       req_tdata,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [CHAR_W-1:0]      rsp_tdata,
   input wire logic                   rsp_tlast
);

   // a stalled character holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   // a valid character word carries known bits
   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !$isunknown({rsp_tdata, rsp_tlast}))
      else $error("rsp word unknown while valid");

   // a character that is not last means a number is still in flight
   a_mid_text_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("ready while text unfinished");

   // output empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind signed_radix_digit_emitter_unit srde_checker u_srde_checker (
   .clock      (clock),
   .reset      (reset),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready),
   .csr_index  (csr_index),
   .csr_data   (csr_data),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for signed_radix_digit_emitter_unit. Loads digit tables
// and radix values through the register port, streams numbers in and checks
// every character word against a local predictor of the expected text. It
// covers good tables, each kind of broken table (which must give no output),
// random receiver and sender gaps, and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
   import srde_pkg::*;

   localparam int CLOCK_HALF     = 5;
   localparam int ITEM_TARGET    = 310;
   localparam int QUIET_ITEMS    = 60;
   localparam int DRAIN_CYCLES   = 1300;
   localparam int SETTLE_LIMIT   = 400000;
   localparam int HOLD_CYCLES    = 3000;
   localparam int TIMEOUT_CYCLES = 5000000;
   localparam int MAX_REPORTS    = 100;

   // indexes past the register list; writes there must change nothing
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_FIRST = 3'd5;

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last;
   } char_word_type;

   typedef enum int {
      FAULT_RADIX_LOW,
      FAULT_RADIX_HIGH,
      FAULT_CHAR_LOW,
      FAULT_CHAR_HIGH,
      FAULT_PLUS,
      FAULT_MINUS,
      FAULT_REPEAT
   } table_fault_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [NUM_W-1:0]       req_tdata  = '0;     // [31:0] number
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b1;
   logic [CHAR_W-1:0]      rsp_tdata;           // [7:0] character
   logic                   rsp_tlast;

   // stimulus and expectation stores
   logic [NUM_W-1:0] number_queue [$];
   char_word_type    pending_chars [$];
   int               error_count = 0;

   // register copies seen by the predictor
   logic [RADIX_W-1:0] shadow_radix  = '0;
   digit_table_type    shadow_digits = '0;

   // idling control
   logic quiet   = 1'b0;
   logic hold_go = 1'b0;
   logic hold_taken;
   int   hold_left, stall_left, calm_left, send_gap, roll;
   char_word_type next_char;

   signed_radix_digit_emitter_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   task automatic report_mismatch(string what);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   // table check: radix in range, every used digit printable, no sign, unique
   function automatic bit table_ok();
      logic [CHAR_W-1:0] c;
      if (shadow_radix < 2 || shadow_radix > MAX_RADIX)
         return 1'b0;
      for (int i = 0; i < shadow_radix; i++) begin
         c = shadow_digits[i];
         if (c < CHAR_LOW || c > CHAR_HIGH || c == CHAR_PLUS || c == CHAR_MINUS)
            return 1'b0;
         for (int j = 0; j < i; j++)
            if (shadow_digits[j] == c)
               return 1'b0;
      end
      return 1'b1;
   endfunction

   // queue the character words one number should produce
   function automatic void spell_number(logic [NUM_W-1:0] number);
      logic [NUM_W-1:0]  mag;
      logic [NUM_W-1:0]  base;
      logic [CHAR_W-1:0] digits [$];
      logic [CHAR_W-1:0] c;
      if (!table_ok())
         return;
      mag  = number;
      base = NUM_W'(shadow_radix);
      if (number[NUM_W-1]) begin
         mag = -number;
         pending_chars.push_back('{character: CHAR_MINUS, last: 1'b0});
      end
      do begin
         digits.push_front(shadow_digits[mag % base]);
         mag = mag / base;
      end while (mag != 0);
      while (digits.size() != 0) begin
         c = digits.pop_front();
         pending_chars.push_back('{character: c, last: (digits.size() == 0)});
      end
   endfunction

   // random good table: distinct printable digits, unused bytes anything
   function automatic digit_table_type random_table(int r);
      digit_table_type   chars;
      bit                taken [256];
      logic [CHAR_W-1:0] c;
      foreach (taken[i])
         taken[i] = 1'b0;
      for (int k = 0; k < MAX_RADIX; k++)
         chars[k] = CHAR_W'($urandom);
      for (int k = 0; k < r; k++) begin
         do
            c = CHAR_W'($urandom_range(CHAR_LOW, CHAR_HIGH));
         while (taken[c] || c == CHAR_PLUS || c == CHAR_MINUS);
         taken[c] = 1'b1;
         chars[k] = c;
      end
      return chars;
   endfunction

   // break a good table (radix >= 2) in one way
   function automatic void apply_fault(input table_fault_type f,
                                       inout digit_table_type chars,
                                       inout logic [RADIX_W-1:0] r);
      int pos;
      pos = $urandom_range((f == FAULT_REPEAT) ? 1 : 0, r - 1);
      case (f)
         FAULT_RADIX_LOW:  r = RADIX_W'($urandom_range(0, 1));
         FAULT_RADIX_HIGH: r = RADIX_W'($urandom_range(MAX_RADIX + 1, 2**RADIX_W - 1));
         FAULT_CHAR_LOW:   chars[pos] = CHAR_W'($urandom_range(0, CHAR_LOW - 1));
         FAULT_CHAR_HIGH:  chars[pos] = CHAR_W'($urandom_range(CHAR_HIGH + 1, 255));
         FAULT_PLUS:       chars[pos] = CHAR_PLUS;
         FAULT_MINUS:      chars[pos] = CHAR_MINUS;
         default:          chars[pos] = chars[$urandom_range(0, pos - 1)];
      endcase
   endfunction

   function automatic logic [NUM_W-1:0] pick_number(int r);
      case ($urandom_range(0, 7))
         0: case ($urandom_range(0, 4))
               0:       return '0;
               1:       return '1;
               2:       return 32'd1;
               3:       return 32'h8000_0000;
               default: return 32'h7FFF_FFFF;
            endcase
         1, 2: return NUM_W'($urandom_range(0, 2 * r * r) - r * r);
         default: return $urandom;
      endcase
   endfunction

   task automatic write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // radix goes out with junk in the bits above the field
   task automatic load_table(logic [RADIX_W-1:0] r, digit_table_type chars);
      logic [CSR_DATA_W-1:0] data;
      data = {$urandom, $urandom};
      data[RADIX_W-1:0] = r;
      write_reg(REG_RADIX, data);
      write_reg(REG_DIGIT_WORD_0, chars[7:0]);
      write_reg(REG_DIGIT_WORD_1, chars[15:8]);
      write_reg(REG_DIGIT_WORD_2, chars[23:16]);
      write_reg(REG_DIGIT_WORD_3, chars[31:24]);
   endtask

   // wait for all numbers taken and all characters back, then let the unit go idle
   task automatic settle();
      int waited;
      waited = 0;
      @(negedge clock);
      while ((number_queue.size() != 0 || req_tvalid || pending_chars.size() != 0)
             && waited < SETTLE_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (pending_chars.size() != 0) begin
         report_mismatch($sformatf("%0d characters never arrived", pending_chars.size()));
         pending_chars.delete();
      end
      repeat (DRAIN_CYCLES)
         @(posedge clock);
   endtask

   // number driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         send_gap   <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap != 0) begin
            send_gap   <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (number_queue.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 99) < 6) begin
            req_tvalid <= 1'b0;
            send_gap   <= $urandom_range(0, 17);
         end else begin
            req_tvalid <= 1'b1;
            req_tdata  <= number_queue.pop_front();
         end
      end
   end

   // receiver ready: random stalls, calm stretches, one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
         hold_taken <= 1'b0;
         hold_left  <= 0;
         stall_left <= 0;
         calm_left  <= 0;
      end else if (hold_go && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= (hold_left == 1);
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else if (quiet || calm_left != 0) begin
         rsp_tready <= 1'b1;
         if (calm_left != 0)
            calm_left <= calm_left - 1;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 10) begin
            stall_left <= $urandom_range(1, 18);
            rsp_tready <= 1'b0;
         end else begin
            if (roll < 13)
               calm_left <= $urandom_range(50, 300);
            rsp_tready <= 1'b1;
         end
      end
   end

   // monitor: register copies, character check, then prediction of new numbers
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_RADIX:        shadow_radix          <= csr_data[RADIX_W-1:0];
               REG_DIGIT_WORD_0: shadow_digits[7:0]    <= csr_data;
               REG_DIGIT_WORD_1: shadow_digits[15:8]   <= csr_data;
               REG_DIGIT_WORD_2: shadow_digits[23:16]  <= csr_data;
               REG_DIGIT_WORD_3: shadow_digits[31:24]  <= csr_data;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected word char %h last %b",
                                         rsp_tdata, rsp_tlast));
            end else begin
               next_char = pending_chars.pop_front();
               if (rsp_tdata !== next_char.character)
                  report_mismatch($sformatf("char %h, want %h",
                                            rsp_tdata, next_char.character));
               if (rsp_tlast !== next_char.last)
                  report_mismatch($sformatf("last %b on char %h, want %b",
                                            rsp_tlast, rsp_tdata, next_char.last));
            end
         end
         if (req_tvalid && req_tready)
            spell_number(req_tdata);
      end
   end

   // main sequence
   initial begin
      digit_table_type    chars;
      digit_table_type    full_chars;
      logic [RADIX_W-1:0] r;
      table_fault_type    fault;
      int                 valid_sent;
      int                 count;
      bit                 broken;

      repeat (4)
         @(posedge clock);
      reset <= 1'b0;

      // registers clear after reset: table invalid, nothing comes out
      @(negedge clock);
      number_queue.push_back(32'd5);
      number_queue.push_back(32'h8000_0000);
      settle();

      // decimal, junk in unused bytes, then spare index writes
      for (int k = 0; k < MAX_RADIX; k++)
         chars[k] = (k < 10) ? CHAR_W'("0" + k) : CHAR_W'($urandom);
      load_table(RADIX_W'(10), chars);
      for (int i = REG_SPARE_FIRST; i < 2**CSR_INDEX_W; i++)
         write_reg(CSR_INDEX_W'(i), {$urandom, $urandom});
      @(negedge clock);
      number_queue.push_back(32'd0);
      number_queue.push_back(32'd1);
      number_queue.push_back(32'hFFFF_FFFF);
      number_queue.push_back(32'd9);
      number_queue.push_back(32'd10);
      number_queue.push_back(32'h7FFF_FFFF);
      number_queue.push_back(32'h8000_0000);
      number_queue.push_back(-32'd12345);
      settle();

      // binary, every unused byte out of range
      chars    = '1;
      chars[0] = "0";
      chars[1] = "1";
      load_table(RADIX_W'(2), chars);
      @(negedge clock);
      number_queue.push_back(32'h8000_0000);
      number_queue.push_back(32'h7FFF_FFFF);
      number_queue.push_back(32'd0);
      number_queue.push_back(32'hFFFF_FFFF);
      settle();

      // full table with both printable extremes
      for (int k = 1; k < MAX_RADIX - 1; k++)
         full_chars[k] = CHAR_W'("A" + k);
      full_chars[0]             = CHAR_LOW;
      full_chars[MAX_RADIX - 1] = CHAR_HIGH;
      load_table(RADIX_W'(MAX_RADIX), full_chars);
      @(negedge clock);
      number_queue.push_back(32'h8000_0000);
      number_queue.push_back(32'h7FFF_FFFF);
      number_queue.push_back(32'd31);
      number_queue.push_back(32'd32);
      settle();

      // each way a table can be broken: one number each, no output
      for (int f = FAULT_RADIX_LOW; f <= FAULT_REPEAT; f++) begin
         chars = full_chars;
         r     = RADIX_W'(MAX_RADIX);
         apply_fault(table_fault_type'(f), chars, r);
         load_table(r, chars);
         @(negedge clock);
         number_queue.push_back($urandom);
         settle();
      end

      // random tables, mostly good; long receiver hold-off in an early good phase
      valid_sent = 0;
      while (valid_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 5))
            0:       r = RADIX_W'(2);
            1:       r = RADIX_W'(MAX_RADIX);
            default: r = RADIX_W'($urandom_range(2, MAX_RADIX));
         endcase
         chars  = random_table(r);
         broken = ($urandom_range(0, 5) == 0);
         if (broken) begin
            fault = table_fault_type'($urandom_range(FAULT_RADIX_LOW, FAULT_REPEAT));
            apply_fault(fault, chars, r);
         end
         if (valid_sent >= ITEM_TARGET - QUIET_ITEMS)
            quiet <= 1'b1;
         load_table(r, chars);
         @(negedge clock);
         count = broken ? 6 : $urandom_range(30, 50);
         repeat (count)
            number_queue.push_back(pick_number(r));
         if (!broken) begin
            if (valid_sent != 0)
               hold_go <= 1'b1;
            valid_sent += count;
         end
         settle();
      end

      if (error_count == 0)
         $display("PASS signed_radix_digit_emitter_unit");
      else
         $display("FAIL signed_radix_digit_emitter_unit");
      $finish;
   end

   // run limit
   initial begin
      #(TIMEOUT_CYCLES * 2 * CLOCK_HALF);
      $display("FAIL signed_radix_digit_emitter_unit");
      $finish;
   end

endmodule
